// ===== rtl/slw_pkg.sv =====
// ----------------------------------------------------------------------------
// slw_pkg
// Shared types and constants for the sleep/wakeup list and its cells.
// ----------------------------------------------------------------------------
package slw_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int TICK_W = 64;
    localparam int ID_W   = 8;
    localparam int DUR_W  = 32;
    localparam int NOW_W  = 63;
    localparam int KIND_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // Operation codes carried on s_tuser.
    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result kinds carried on m_tuser.
    localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETURNED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic compare;   // latch the due flag against the current tick
        logic load;      // the cell whose index matches the target takes load data
        logic shift;     // every other cell takes its upper neighbor's contents
    } slw_ctrl_t;

endpackage

// ===== rtl/slw_cell.sv =====
// ----------------------------------------------------------------------------
// slw_cell
// One entry of the sleeper chain: thread id, wake tick and due flag.
// ----------------------------------------------------------------------------
module slw_cell #(
    parameter int SLOTS = slw_pkg::SLOTS_DEFAULT,
    parameter int INDEX = 0,
    parameter int CW    = $clog2(SLOTS + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  slw_pkg::slw_ctrl_t        ctrl,
    input  logic [CW-1:0]             tgt,
    input  logic [CW-1:0]             cnt,
    input  logic [slw_pkg::TICK_W-1:0] tick,
    input  logic [slw_pkg::ID_W-1:0]   load_id,
    input  logic [slw_pkg::TICK_W-1:0] load_wake,
    input  logic [slw_pkg::ID_W-1:0]   in_id,
    input  logic [slw_pkg::TICK_W-1:0] in_wake,
    input  logic                      in_due,
    output logic [slw_pkg::ID_W-1:0]   out_id,
    output logic [slw_pkg::TICK_W-1:0] out_wake,
    output logic                      out_due
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [slw_pkg::ID_W-1:0]   id_reg;
    logic [slw_pkg::TICK_W-1:0] wake_reg;
    logic                       due_reg;

    // Payload registers follow the chain without reset.
    always_ff @(posedge aclk) begin
        if (ctrl.load && (tgt == IDX)) begin
            id_reg   <= load_id;
            wake_reg <= load_wake;
        end else if (ctrl.shift) begin
            id_reg   <= in_id;
            wake_reg <= in_wake;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            due_reg <= 1'b0;
        end else if (ctrl.compare) begin
            due_reg <= (IDX < cnt) && (wake_reg <= tick);
        end else if (ctrl.load && (tgt == IDX)) begin
            due_reg <= 1'b0;
        end else if (ctrl.shift) begin
            due_reg <= in_due;
        end
    end

    assign out_id   = id_reg;
    assign out_wake = wake_reg;
    assign out_due  = due_reg;

endmodule

// ===== rtl/sleep_wakeup_list.sv =====
// ----------------------------------------------------------------------------
// sleep_wakeup_list
// Alarm-clock sleep queue: a tick counter and a chain of sleeping threads.
// ----------------------------------------------------------------------------
// A request on the s_ channel is either a sleep request (s_tuser = 0) or one
// timer tick (s_tuser = 1). A sleep request with a positive duration is
// appended to the end of the list with wake tick now + duration and gives no
// result; a zero or negative duration comes straight back with kind 1, and a
// positive one that finds all SLOTS entries in use is rejected with kind 2.
// A tick advances the 64-bit counter, then every cell compares its wake tick
// against the new count in parallel, and the chain is then rotated once
// through its head cell, one entry per cycle while no due head entry waits
// on the m_ side: due entries leave as results in insertion order, the others
// go back to the tail. The block takes no new request until the tick's sweep
// is done. The last result caused by a request carries m_tlast. Counter and
// wake ticks wrap modulo 2^64 and compare unsigned; m_tdata reports the low
// 63 bits of the count.
// ----------------------------------------------------------------------------
module sleep_wakeup_list #(
    parameter int SLOTS = slw_pkg::SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Request channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] thread_id, [39:8] sleep_ticks (signed)
    input  logic [slw_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                          s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] thread_id_res, [70:8] now_tick, [71] zero
    output logic [slw_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [slw_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);

    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_SWEEP   = 2'd2;

    localparam logic [CW-1:0] FULL = CW'(SLOTS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [1:0]                   state_reg, state_next;
    logic [slw_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                rem_reg, rem_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [slw_pkg::ID_W-1:0]     m_id_reg, m_id_next;
    logic [slw_pkg::NOW_W-1:0]    m_now_reg, m_now_next;
    logic [slw_pkg::KIND_W-1:0]   m_kind_reg, m_kind_next;
    logic                         m_last_reg, m_last_next;

    // Request fields.
    logic                         req_op;
    logic [slw_pkg::ID_W-1:0]     req_id;
    logic [slw_pkg::DUR_W-1:0]    req_dur;
    logic                         req_positive;
    logic                         accept;
    logic                         out_free;

    // Chain wiring.
    slw_pkg::slw_ctrl_t           ctrl;
    logic [CW-1:0]                tgt;
    logic [slw_pkg::ID_W-1:0]     load_id;
    logic [slw_pkg::TICK_W-1:0]   load_wake;
    logic [slw_pkg::ID_W-1:0]     cell_id   [SLOTS];
    logic [slw_pkg::TICK_W-1:0]   cell_wake [SLOTS];
    logic [SLOTS-1:0]             cell_due;
    logic                         others_due;

    assign req_op       = s_tuser;
    assign req_id       = s_tdata[7:0];
    assign req_dur      = s_tdata[39:8];
    assign req_positive = (req_dur != '0) && !req_dur[slw_pkg::DUR_W-1];

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Any due entry behind the head means the head is not the last result.
    assign others_due = |(cell_due & ~SLOTS'(1));

    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        count_next    = count_reg;
        rem_next      = rem_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_id_next     = m_id_reg;
        m_now_next    = m_now_reg;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        ctrl          = '0;
        tgt           = count_reg;
        load_id       = req_id;
        load_wake     = tick_reg + {{(slw_pkg::TICK_W - slw_pkg::DUR_W){1'b0}}, req_dur};

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_op == slw_pkg::OP_TICK) begin
                        tick_next  = tick_reg + 64'd1;
                        state_next = ST_COMPARE;
                    end else if (!req_positive || (count_reg == FULL)) begin
                        m_tvalid_next = 1'b1;
                        m_id_next     = req_id;
                        m_now_next    = tick_reg[slw_pkg::NOW_W-1:0];
                        m_kind_next   = req_positive ? slw_pkg::KIND_REJECTED
                                                     : slw_pkg::KIND_RETURNED;
                        m_last_next   = 1'b1;
                    end else begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + ONE;
                    end
                end
            end
            ST_COMPARE: begin
                ctrl.compare = 1'b1;
                rem_next     = count_reg;
                state_next   = (count_reg == '0) ? ST_IDLE : ST_SWEEP;
            end
            ST_SWEEP: begin
                tgt       = count_reg - ONE;
                load_id   = cell_id[0];
                load_wake = cell_wake[0];
                if (!cell_due[0] || out_free) begin
                    ctrl.shift = 1'b1;
                    if (cell_due[0]) begin
                        count_next    = count_reg - ONE;
                        m_tvalid_next = 1'b1;
                        m_id_next     = cell_id[0];
                        m_now_next    = tick_reg[slw_pkg::NOW_W-1:0];
                        m_kind_next   = slw_pkg::KIND_WOKEN;
                        m_last_next   = !others_due;
                    end else begin
                        // Kept entry goes back to the tail of the list.
                        ctrl.load = 1'b1;
                    end
                    rem_next = rem_reg - ONE;
                    if (rem_reg == ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            count_reg    <= '0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            count_reg    <= count_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_id_reg   <= m_id_next;
        m_now_reg  <= m_now_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    // The chain of cells: cell 0 holds the oldest entry.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic [slw_pkg::ID_W-1:0]   nb_id;
        logic [slw_pkg::TICK_W-1:0] nb_wake;
        logic                       nb_due;

        if (i == SLOTS - 1) begin : g_tail
            assign nb_id   = '0;
            assign nb_wake = '0;
            assign nb_due  = 1'b0;
        end else begin : g_body
            assign nb_id   = cell_id[i+1];
            assign nb_wake = cell_wake[i+1];
            assign nb_due  = cell_due[i+1];
        end

        slw_cell #(
            .SLOTS (SLOTS),
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .tgt       (tgt),
            .cnt       (count_reg),
            .tick      (tick_reg),
            .load_id   (load_id),
            .load_wake (load_wake),
            .in_id     (nb_id),
            .in_wake   (nb_wake),
            .in_due    (nb_due),
            .out_id    (cell_id[i]),
            .out_wake  (cell_wake[i]),
            .out_due   (cell_due[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_now_reg, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
